[rtl/core/bih_pkg.sv]
// ============================================================================
// bih_pkg
// Shared types and constants of the block intersection histogram.
// ============================================================================
package bih_pkg;

    localparam int unsigned BIH_MAX_POINTS = 63;
    localparam int unsigned BIH_MAX_BLOCKS = 256;

    localparam int unsigned BIH_WORD_W  = 64;   // popcount word, padded
    localparam int unsigned BIH_SIZE_W  = 6;
    localparam int unsigned BIH_COUNT_W = 15;
    localparam int unsigned BIH_BINS    = 64;
    localparam int unsigned BIH_CFG_W   = 9;
    localparam int unsigned BIH_NP_W    = 6;

    localparam logic BIH_CFG_NUM_POINTS = 1'b0;
    localparam logic BIH_CFG_NUM_BLOCKS = 1'b1;

    localparam logic [BIH_COUNT_W-1:0] BIH_COUNT_MAX = {BIH_COUNT_W{1'b1}};

    // histogram chain control, broadcast to every cell
    typedef struct packed {
        logic                  inc;
        logic [BIH_SIZE_W-1:0] size;
        logic                  shift;
    } t_cell_ctl;

endpackage

[rtl/core/bih_cell.sv]
// ============================================================================
// bih_cell
// One histogram bin: counts hits on its own size, shifts toward the head.
// ============================================================================
module bih_cell
    import bih_pkg::*;
#(
    parameter int unsigned BIN = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [BIH_COUNT_W-1:0] i_shift_in,
    output logic [BIH_COUNT_W-1:0] o_count
);

    localparam logic [BIH_SIZE_W-1:0] MyBin = BIH_SIZE_W'(BIN);

    logic [BIH_COUNT_W-1:0] r_count;
    logic [BIH_COUNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.shift) begin
            n_count = i_shift_in;
        end else if (i_ctl.inc && (i_ctl.size == MyBin) && (r_count != BIH_COUNT_MAX)) begin
            n_count = r_count + BIH_COUNT_W'(1);   // saturating
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

[rtl/core/bih_store.sv]
// ============================================================================
// bih_store
// Block store: one write port, one registered read port.
// ============================================================================
module bih_store #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned WIDTH  = 63,
    parameter int unsigned ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/block_intersection_histogram_unit.sv]
// ============================================================================
// block_intersection_histogram_unit
// Pairwise intersection-size histogram over the blocks of a design.
// ============================================================================
// Usage:
//   Slave stream: one block per item, tdata[62:0] = member bitmask.
//   Master stream: one item per nonzero histogram bin, rising size order,
//   tdata = {pair_count, intersection_size}, tlast on the final bin.
//   A design of one block yields a single (0, 0) item with tlast.
//   Config port: i_cfg_idx 0 = num_points, 1 = num_blocks; write only
//   while the block is idle.
// Flow:
//   A block with k earlier blocks stored is compared against them before
//   the next block is taken: k store reads, then the read / AND / partial
//   popcount / sum pipeline, then the bin update. The single store read
//   port sets this pace. After the last block of a design the histogram
//   chain shifts out one bin per cycle while the output is free, up to the
//   highest nonzero bin.
// Reset: histogram cells, block count and config return to their reset
//   values; the store needs no clearing.
// Stall: the output register holds while tready is low and the chain
//   stops shifting; a block may be taken while the last result waits.
// ============================================================================
module block_intersection_histogram_unit
    import bih_pkg::*;
#(
    parameter int unsigned MAX_POINTS = BIH_MAX_POINTS,
    parameter int unsigned MAX_BLOCKS = BIH_MAX_BLOCKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [BIH_CFG_W-1:0] i_cfg_wdata,
    // block items
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [63:0]          i_s_tdata,   // [62:0] members, [63] zero pad
    // histogram items
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,   // [5:0] intersection_size,
                                              // [20:6] pair_count, [23:21] pad
    output logic                 o_m_tlast    // last_result
);

    localparam int unsigned AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned LW     = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CW     = (LW > BIH_CFG_W) ? LW : BIH_CFG_W;
    localparam int unsigned NPART  = BIH_WORD_W / 8;
    localparam int unsigned PART_W = 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COMP  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [BIH_NP_W-1:0]  r_num_points;
    logic [BIH_CFG_W-1:0] r_num_blocks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= BIH_NP_W'(63);
            r_num_blocks <= BIH_CFG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                BIH_CFG_NUM_POINTS: r_num_points <= i_cfg_wdata[BIH_NP_W-1:0];
                BIH_CFG_NUM_BLOCKS: r_num_blocks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // points mask: bits below min(num_points, MAX_POINTS)
    logic [BIH_NP_W-1:0]   w_pts;
    logic [MAX_POINTS-1:0] w_mask;
    logic [MAX_POINTS-1:0] w_blk;

    assign w_pts = (r_num_points > BIH_NP_W'(MAX_POINTS)) ? BIH_NP_W'(MAX_POINTS)
                                                          : r_num_points;
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            w_mask[i] = (BIH_NP_W'(i) < w_pts);
        end
    end
    assign w_blk = i_s_tdata[MAX_POINTS-1:0] & w_mask;

    // block count clamped to 1..MAX_BLOCKS
    logic [CW-1:0] w_nb;
    logic [CW-1:0] w_total;

    assign w_nb = CW'(r_num_blocks);
    always_comb begin
        if (w_nb == '0) begin
            w_total = CW'(1);
        end else if (w_nb > CW'(MAX_BLOCKS)) begin
            w_total = CW'(MAX_BLOCKS);
        end else begin
            w_total = w_nb;
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic [1:0]            r_state, n_state;
    logic [LW-1:0]         r_loaded, n_loaded;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic [AW-1:0]         r_last_rd, n_last_rd;
    logic                  r_done, n_done;
    logic [MAX_POINTS-1:0] r_blk;
    logic [BIH_SIZE_W-1:0] r_drain_idx, n_drain_idx;
    logic [BIH_SIZE_W-1:0] r_max, n_max;
    logic                  r_any, n_any;

    logic                  w_accept;
    logic [AW-1:0]         w_idx;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [BIH_SIZE_W-1:0] w_out_size;
    logic [BIH_COUNT_W-1:0] w_out_count;
    logic                  w_out_last;
    logic                  w_shift;

    logic                  r_p1, r_p2, r_p3;
    logic [BIH_SIZE_W-1:0] r_size;

    logic [BIH_COUNT_W-1:0] w_count [BIH_BINS+1];

    logic                  r_out_valid;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // write slot of the new block; the top slot is reused past the depth
    assign w_idx = (r_loaded >= LW'(MAX_BLOCKS)) ? AW'(MAX_BLOCKS - 1) : r_loaded[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_rd_idx    = r_rd_idx;
        n_last_rd   = r_last_rd;
        n_done      = r_done;
        n_drain_idx = r_drain_idx;
        n_max       = r_max;
        n_any       = r_any;
        w_out_load  = 1'b0;
        w_out_size  = '0;
        w_out_count = '0;
        w_out_last  = 1'b0;
        w_shift     = 1'b0;

        // bin update stage tracks the highest bin hit
        if (r_p3) begin
            n_any = 1'b1;
            if (!r_any || (r_size > r_max)) begin
                n_max = r_size;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_rd_idx  = '0;
                    n_last_rd = w_idx - AW'(1);
                    if ((CW'(w_idx) + CW'(1)) >= w_total) begin
                        n_done   = 1'b1;
                        n_loaded = '0;
                    end else begin
                        n_done   = 1'b0;
                        n_loaded = LW'(w_idx) + LW'(1);
                    end
                    n_state = (w_idx == '0) ? ST_WAIT : ST_COMP;
                end
            end
            ST_COMP: begin
                n_rd_idx = r_rd_idx + AW'(1);
                if (r_rd_idx == r_last_rd) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_p1 && !r_p2 && !r_p3) begin
                    n_state = r_done ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    if (!r_any) begin
                        // no pairs in the design
                        w_out_load = 1'b1;
                        w_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        w_shift     = 1'b1;
                        w_out_load  = (w_count[0] != '0);
                        w_out_size  = r_drain_idx;
                        w_out_count = w_count[0];
                        w_out_last  = (r_drain_idx == r_max);
                        if (r_drain_idx == r_max) begin
                            n_state     = ST_IDLE;
                            n_drain_idx = '0;
                            n_any       = 1'b0;
                            n_max       = '0;
                        end else begin
                            n_drain_idx = r_drain_idx + BIH_SIZE_W'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loaded    <= '0;
            r_rd_idx    <= '0;
            r_last_rd   <= '0;
            r_done      <= 1'b0;
            r_drain_idx <= '0;
            r_max       <= '0;
            r_any       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_rd_idx    <= n_rd_idx;
            r_last_rd   <= n_last_rd;
            r_done      <= n_done;
            r_drain_idx <= n_drain_idx;
            r_max       <= n_max;
            r_any       <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_blk <= w_blk;
        end
    end

    // ------------------------------------------------------------------
    // store and compare pipeline: read -> AND + partial counts -> sum
    // ------------------------------------------------------------------
    logic [MAX_POINTS-1:0] w_rdata;
    logic [BIH_WORD_W-1:0] w_and;
    logic [PART_W-1:0]     r_part [NPART];

    bih_store #(
        .DEPTH  (MAX_BLOCKS),
        .WIDTH  (MAX_POINTS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_idx),
        .i_wdata (w_blk),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign w_and = BIH_WORD_W'(w_rdata & r_blk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
            r_p3 <= 1'b0;
        end else begin
            r_p1 <= (r_state == ST_COMP);
            r_p2 <= r_p1;
            r_p3 <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [PART_W-1:0]     v_cnt;
        logic [BIH_SIZE_W:0]   v_sum;
        for (int p = 0; p < NPART; p++) begin
            v_cnt = '0;
            for (int b = 0; b < 8; b++) begin
                v_cnt = v_cnt + PART_W'(w_and[p*8+b]);
            end
            r_part[p] <= v_cnt;
        end
        v_sum = '0;
        for (int p = 0; p < NPART; p++) begin
            v_sum = v_sum + (BIH_SIZE_W+1)'(r_part[p]);
        end
        r_size <= v_sum[BIH_SIZE_W-1:0];
    end

    // ------------------------------------------------------------------
    // histogram chain, cell 0 at the output end
    // ------------------------------------------------------------------
    t_cell_ctl w_ctl;

    assign w_ctl.inc   = r_p3;
    assign w_ctl.size  = r_size;
    assign w_ctl.shift = w_shift;

    assign w_count[BIH_BINS] = '0;

    for (genvar k = 0; k < BIH_BINS; k++) begin : g_cell
        bih_cell #(
            .BIN (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_shift_in (w_count[k+1]),
            .o_count    (w_count[k])
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [BIH_SIZE_W-1:0]  r_out_size;
    logic [BIH_COUNT_W-1:0] r_out_count;
    logic                   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_size  <= w_out_size;
            r_out_count <= w_out_count;
            r_out_last  <= w_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_size};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // a new block is only taken with the compare pipeline empty
    a_ready_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!r_p1 && !r_p2 && !r_p3))
        else $error("block taken while compare pipeline busy");

    // the final result of a design returns control to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_out_last) |=> (r_state == ST_IDLE))
        else $error("final result loaded but design not closed");

    // every bin update marks the histogram as holding pairs
    a_hit_sets_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3 && (r_state != ST_DRAIN)) |=> r_any)
        else $error("bin update lost its pair flag");

    // block count never passes the store depth
    a_loaded_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= LW'(MAX_BLOCKS))
        else $error("block count beyond store depth");

    // the chain must not shift while a result is still blocked
    a_shift_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> w_out_free)
        else $error("histogram shifted into a stalled output");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: block intersection histogram unit
// Streams designs of point-membership blocks into the unit, predicts the
// pairwise intersection-size histogram of each design and checks every
// emitted histogram item in order. Gaps, receiver stalls, one long receiver
// hold-off and register changes between and inside designs are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bih_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = BIH_MAX_BLOCKS + BIH_BINS + 16;
    localparam int unsigned RX_HOLD_CYCLES = 3000;
    localparam int unsigned RAND_ITEMS     = 128;
    localparam int unsigned RAND_BINS      = 48;

    // one expected histogram item
    typedef struct {
        bit [BIH_SIZE_W-1:0]  size;
        bit [BIH_COUNT_W-1:0] count;
        bit                   last;
    } t_hist_bin;

    // ------------------------------------------------------------------------
    // Histogram predictor and expected-item store
    // ------------------------------------------------------------------------
    class intersection_scoreboard;
        t_hist_bin            bins_due[$];
        bit [BIH_NP_W-1:0]    num_points = BIH_NP_W'(BIH_MAX_POINTS);
        bit [BIH_CFG_W-1:0]   num_blocks = BIH_CFG_W'(BIH_MAX_BLOCKS);
        bit [62:0]            block_mem [BIH_MAX_BLOCKS];
        bit [BIH_COUNT_W-1:0] size_hist [BIH_BINS];
        int unsigned          loaded;
        int unsigned          errors;
        int unsigned          bins_made;

        function new();
            foreach (size_hist[i]) size_hist[i] = '0;
            foreach (block_mem[i]) block_mem[i] = '0;
            loaded    = 0;
            errors    = 0;
            bins_made = 0;
        endfunction

        function void write_reg(logic idx, bit [BIH_CFG_W-1:0] val);
            if (idx == BIH_CFG_NUM_POINTS) num_points = val[BIH_NP_W-1:0];
            else                           num_blocks = val;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        // one accepted block; queues the design's histogram when it completes
        function void take_block(bit [62:0] members);
            bit [63:0]   mask;
            bit [62:0]   blk;
            int unsigned total;
            int unsigned idx;
            int unsigned s;
            int unsigned found;
            t_hist_bin   hb;
            mask  = (num_points == 0) ? 64'd0 : ((64'd1 << num_points) - 64'd1);
            blk   = members & mask[62:0];
            total = (num_blocks == 0) ? 1 :
                    (num_blocks > BIH_MAX_BLOCKS) ? BIH_MAX_BLOCKS : num_blocks;
            idx   = (loaded >= BIH_MAX_BLOCKS) ? BIH_MAX_BLOCKS - 1 : loaded;
            for (int i = 0; i < idx; i++) begin
                s = $countones(block_mem[i] & blk);
                if (size_hist[s] != BIH_COUNT_MAX) size_hist[s]++;
            end
            block_mem[idx] = blk;
            loaded = idx + 1;
            if (loaded < total) return;
            found = 0;
            for (int i = 0; i < BIH_BINS; i++) begin
                if (size_hist[i] != 0) begin
                    hb.size  = BIH_SIZE_W'(i);
                    hb.count = size_hist[i];
                    hb.last  = 1'b0;
                    bins_due.push_back(hb);
                    found++;
                end
            end
            if (found == 0) begin
                // single block: no pairs at all
                hb.size  = '0;
                hb.count = '0;
                hb.last  = 1'b1;
                bins_due.push_back(hb);
                found = 1;
            end else begin
                bins_due[bins_due.size()-1].last = 1'b1;
            end
            bins_made += found;
            foreach (size_hist[i]) size_hist[i] = '0;
            loaded = 0;
        endfunction

        task check_bin(bit [BIH_SIZE_W-1:0] size, bit [BIH_COUNT_W-1:0] count,
                       bit last);
            t_hist_bin want;
            if (bins_due.size() == 0) begin
                report($sformatf("unexpected item size=%0d count=%0d last=%0b",
                                 size, count, last));
                return;
            end
            want = bins_due.pop_front();
            if (size != want.size)
                report($sformatf("size %0d, want %0d", size, want.size));
            if (count != want.count)
                report($sformatf("count %0d, want %0d (size %0d)",
                                 count, want.count, want.size));
            if (last != want.last)
                report($sformatf("tlast %0b, want %0b (size %0d)",
                                 last, want.last, want.size));
        endtask

        task check_drained();
            if (bins_due.size() != 0)
                report($sformatf("%0d expected items never came", bins_due.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [BIH_CFG_W-1:0] i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [63:0]          i_s_tdata;   // [62:0] members, [63] zero pad
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [23:0]          o_m_tdata;   // [5:0] intersection_size, [20:6] pair_count
    logic                 o_m_tlast;   // last_result

    intersection_scoreboard sb = new();

    bit          no_idle     = 1'b0;   // gap-free stretch on both sides
    bit          rx_hold_req = 1'b0;   // asks the receiver for a long hold-off
    int unsigned rand_items  = 0;

    block_intersection_histogram_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #(8_000_000);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_bin(o_m_tdata[BIH_SIZE_W-1:0],
                             o_m_tdata[BIH_SIZE_W+BIH_COUNT_W-1:BIH_SIZE_W],
                             o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                sb.take_block(i_s_tdata[62:0]);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // member masks of varied density so intersections spread over many sizes
    function automatic bit [62:0] rand_members();
        bit [63:0]   a;
        bit [63:0]   b;
        bit [63:0]   c;
        bit [63:0]   m;
        int unsigned r;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        case (r)
            0:       m = '1;
            1:       m = '0;
            2, 3, 4: m = a & b & c;
            5, 6:    m = a | b;
            default: m = a;
        endcase
        return m[62:0];
    endfunction

    function automatic int unsigned blocks_of(bit [BIH_CFG_W-1:0] nb);
        if (nb == 0) return 1;
        if (nb > BIH_MAX_BLOCKS) return BIH_MAX_BLOCKS;
        return nb;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long counted hold-off on request
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int unsigned stall;
        int unsigned hold;
        stall = 0;
        hold  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold = RX_HOLD_CYCLES;
            end
            if (hold != 0) begin
                i_m_tready = 1'b0;
                hold--;
            end else if (stall != 0) begin
                i_m_tready = 1'b0;
                stall--;
            end else begin
                i_m_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks, all entered at a falling edge
    // ------------------------------------------------------------------------
    task send_block(bit [62:0] members);
        int unsigned gap;
        i_s_tdata  = {1'b0, members};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task write_reg(logic idx, bit [BIH_CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task set_design(bit [BIH_NP_W-1:0] np, bit [BIH_CFG_W-1:0] nb);
        write_reg(BIH_CFG_NUM_POINTS, {{(BIH_CFG_W-BIH_NP_W){1'b0}}, np});
        write_reg(BIH_CFG_NUM_BLOCKS, nb);
    endtask

    // pause input until all expected items are out, then let the unit drain
    task settle();
        i_s_tvalid = 1'b0;
        while (sb.bins_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task random_design(bit [BIH_NP_W-1:0] np, bit [BIH_CFG_W-1:0] nb);
        int unsigned n;
        set_design(np, nb);
        n = blocks_of(nb);
        repeat (n) send_block(rand_members());
        rand_items += n;
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stim
        bit [BIH_NP_W-1:0]  np;
        bit [BIH_CFG_W-1:0] nb;
        int unsigned        r;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = BIH_CFG_NUM_POINTS;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // one-block design: no pairs, single (0,0) item
        set_design(BIH_NP_W'(BIH_MAX_POINTS), 1);
        send_block('1);
        settle();

        // block count zero acts as one
        set_design(BIH_NP_W'(BIH_MAX_POINTS), 0);
        send_block('0);
        settle();

        // full masks meet in all 63 points
        set_design(BIH_NP_W'(BIH_MAX_POINTS), 2);
        send_block('1);
        send_block('1);
        settle();

        set_design(BIH_NP_W'(BIH_MAX_POINTS), 3);
        send_block('0);
        send_block('1);
        send_block(63'h5555_5555_5555_5555);
        settle();

        // zero points: every bit masked off
        set_design(0, 2);
        send_block('1);
        send_block('1);
        settle();

        // one point, every block holds it
        set_design(1, 3);
        repeat (3) send_block(rand_members() | 63'd1);
        settle();

        // bits above the design's points are dropped
        set_design(32, 4);
        send_block('1);
        send_block(rand_members());
        send_block({31'h7fff_ffff, 32'h0});
        send_block(rand_members());
        settle();

        // block count lowered below the loaded count mid-design:
        // the next block closes the design
        set_design(BIH_NP_W'(BIH_MAX_POINTS), 5);
        repeat (3) send_block(rand_members());
        settle();
        write_reg(BIH_CFG_NUM_BLOCKS, 2);
        send_block(rand_members());
        settle();

        // long receiver hold-off while blocks keep coming: input backs up
        set_design(BIH_NP_W'(BIH_MAX_POINTS), 2);
        no_idle     = 1'b1;
        rx_hold_req = 1'b1;
        repeat (12) send_block(rand_members());
        settle();
        no_idle = 1'b0;

        // random designs, mostly small
        while (rand_items < RAND_ITEMS || sb.bins_made < RAND_BINS) begin
            r = $urandom_range(0, 99);
            if (r < 20)      np = BIH_NP_W'(BIH_MAX_POINTS);
            else if (r < 30) np = 1;
            else if (r < 35) np = 0;
            else             np = BIH_NP_W'($urandom_range(1, BIH_MAX_POINTS));
            r = $urandom_range(0, 99);
            if (r < 10)      nb = 0;
            else if (r < 25) nb = 1;
            else if (r < 95) nb = BIH_CFG_W'($urandom_range(2, 8));
            else             nb = BIH_CFG_W'($urandom_range(9, 24));
            no_idle = ($urandom_range(0, 3) == 0);
            random_design(np, nb);
        end
        no_idle = 1'b0;

        sb.check_drained();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
